// ----- rtl/stle_pkg.sv -----
// shared constants and codes for the session table lifecycle engine
`default_nettype none

package stle_pkg;

  // table geometry
  localparam int ENTRIES_DEF = 8;
  localparam int ENTRIES_MAX = 64;

  // configuration register file
  localparam int NREGS  = 8;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_STEP      = 3'd0;
  localparam logic [2:0] REG_NEW_TO    = 3'd1;
  localparam logic [2:0] REG_HS_TO     = 3'd2;
  localparam logic [2:0] REG_AUTH_TO   = 3'd3;
  localparam logic [2:0] REG_NAUTH_TO  = 3'd4;
  localparam logic [2:0] REG_MANAGED_TO = 3'd5;
  localparam logic [2:0] REG_EXPIRED_TO = 3'd6;
  localparam logic [2:0] REG_OLD_TO    = 3'd7;

  localparam logic [DATA_W-1:0] CFG_RESET [NREGS] = '{
    32'd100, 32'd1000, 32'd5000, 32'd1000,
    32'd10000, 32'd60000, 32'd10000, 32'd10000
  };

  // operation codes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_MANAGE = 3'd1;
  localparam logic [2:0] OP_OPEN   = 3'd2;
  localparam logic [2:0] OP_HS     = 3'd3;
  localparam logic [2:0] OP_FIND   = 3'd4;

  // session state codes
  localparam logic [3:0] ST_EMPTY   = 4'd0;
  localparam logic [3:0] ST_NEW     = 4'd1;
  localparam logic [3:0] ST_INIT    = 4'd2;
  localparam logic [3:0] ST_AUTH    = 4'd3;
  localparam logic [3:0] ST_NAUTH   = 4'd4;
  localparam logic [3:0] ST_AUTZ    = 4'd5;
  localparam logic [3:0] ST_NAUTZ   = 4'd6;
  localparam logic [3:0] ST_MANAGED = 4'd7;
  localparam logic [3:0] ST_EXPIRED = 4'd8;
  localparam logic [3:0] ST_OLD     = 4'd9;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_REFUSED = 2'd2;
  localparam logic [1:0] STAT_NOMATCH = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/session_table_lifecycle_engine_core.sv -----
// session table lifecycle engine: entry table, scan sequencer and apb register file
// flow: a tick or find scans every entry, manage and remote open scan and then write the
//   allocation, a handshake result visits one entry, an unused opcode goes straight to done
// items: a new item is taken only once the last one is in the result register; the single
//   table read port, visited one entry per cycle by the scan sequencer, sets the pace
// reset: synchronous active-low rst_n restores register defaults and clears the per
//   entry valid bits so every entry reads as empty; there is no clearing pass
`default_nettype none

module session_table_lifecycle_engine_core #(
  parameter int ENTRIES = stle_pkg::ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  // apb register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [stle_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [stle_pkg::DATA_W-1:0]   pwdata,
  output logic      [stle_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,

  // input item channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0]                    in_opcode,
  input  wire logic [31:0]                   in_peer_id,
  input  wire logic [2:0]                    in_slot,
  input  wire logic                          in_handshake_ok,
  input  wire logic                          in_start_ok,
  input  wire logic [7:0]                    in_start_grant_mask,

  // result item channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic [2:0]                         out_entry,
  output logic [31:0]                        out_time_left,
  output logic [7:0]                         out_stop_mask,
  output logic [7:0]                         out_start_request_mask
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } fsm_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [stle_pkg::DATA_W-1:0] cfg_r [stle_pkg::NREGS];
  logic                        cfg_we;
  logic [2:0]                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel & penable & pwrite & pready;
  assign prdata  = cfg_r[cfg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < stle_pkg::NREGS; k++) begin
        cfg_r[k] <= stle_pkg::CFG_RESET[k];
      end
    end else if (cfg_we) begin
      cfg_r[cfg_idx] <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // entry table: one read port with registered data, one write port
  // per-entry valid bits stand in for the all-zero reset contents
  // ---------------------------------------------------------------------------
  logic [3:0]         state_mem [ENTRIES];
  logic [31:0]        peer_mem  [ENTRIES];
  logic [31:0]        time_mem  [ENTRIES];
  logic [ENTRIES-1:0] vld_r;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [3:0]         rd_state_r;
  logic [31:0]        rd_peer_r;
  logic [31:0]        rd_time_r;
  logic               rd_vld_r;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [3:0]         wr_state;
  logic [31:0]        wr_peer;
  logic [31:0]        wr_time;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      state_mem[wr_addr] <= wr_state;
      peer_mem[wr_addr]  <= wr_peer;
      time_mem[wr_addr]  <= wr_time;
    end
    if (rd_en) begin
      rd_state_r <= state_mem[rd_addr];
      rd_peer_r  <= peer_mem[rd_addr];
      rd_time_r  <= time_mem[rd_addr];
      rd_vld_r   <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // never-written entries read as empty with zero peer and timer
  logic [3:0]  rd_st;
  logic [31:0] rd_peer;
  logic [31:0] rd_time;

  assign rd_st   = rd_vld_r ? rd_state_r : stle_pkg::ST_EMPTY;
  assign rd_peer = rd_vld_r ? rd_peer_r  : 32'd0;
  assign rd_time = rd_vld_r ? rd_time_r  : 32'd0;

  // ---------------------------------------------------------------------------
  // sequencer and item registers
  // ---------------------------------------------------------------------------
  fsm_t             fsm_r, fsm_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [31:0]      peer_r, peer_nxt;
  logic             hs_ok_r, hs_ok_nxt;
  logic             start_ok_r, start_ok_nxt;
  logic [7:0]       grant_r, grant_nxt;

  logic [IDX_W-1:0] idx_r, idx_nxt;     // read address of the scan
  logic             iss_r, iss_nxt;     // reads still to issue
  logic             pv_r, pv_nxt;       // read data valid this cycle
  logic [IDX_W-1:0] pidx_r, pidx_nxt;   // entry whose data is in the read register
  logic             plast_r, plast_nxt; // that entry is the last of the scan

  // per-item accumulators
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] fe_r, fe_nxt;
  logic [31:0]      best_r, best_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [2:0]       entry_r, entry_nxt;
  logic [7:0]       stop_r, stop_nxt;
  logic [7:0]       req_r, req_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [2:0]       out_entry_r, out_entry_nxt;
  logic [31:0]      out_time_r, out_time_nxt;
  logic [7:0]       out_stop_r, out_stop_nxt;
  logic [7:0]       out_req_r, out_req_nxt;

  // ---------------------------------------------------------------------------
  // tick transition of one entry: timeout check, then state advance
  // ---------------------------------------------------------------------------
  logic [3:0]  tk_st2;
  logic [31:0] tk_t2;
  logic        tk_clr;
  logic        tk_stop;
  logic        tk_req;
  logic [7:0]  pbit;
  logic        tk_grant;

  assign pbit     = 8'd1 << pidx_r;   // zero for entries past the mask width
  assign tk_grant = (pbit & grant_r) != 8'd0;

  always_comb begin
    logic [3:0]  st1;
    logic [31:0] t1;
    st1     = rd_st;
    t1      = rd_time;
    tk_clr  = 1'b0;
    tk_stop = 1'b0;
    tk_req  = 1'b0;
    if (rd_time == 32'd0) begin
      if (rd_st inside {stle_pkg::ST_NEW, stle_pkg::ST_AUTH, stle_pkg::ST_NAUTH,
                        stle_pkg::ST_AUTZ, stle_pkg::ST_NAUTZ, stle_pkg::ST_EXPIRED}) begin
        st1 = stle_pkg::ST_OLD;
        t1  = cfg_r[stle_pkg::REG_OLD_TO];
      end else if (rd_st == stle_pkg::ST_INIT) begin
        st1     = stle_pkg::ST_NAUTH;
        t1      = cfg_r[stle_pkg::REG_NAUTH_TO];
        tk_stop = 1'b1;
      end else if (rd_st == stle_pkg::ST_MANAGED) begin
        st1 = stle_pkg::ST_EXPIRED;
        t1  = cfg_r[stle_pkg::REG_EXPIRED_TO];
      end else if (rd_st == stle_pkg::ST_OLD) begin
        st1    = stle_pkg::ST_EMPTY;
        t1     = 32'd0;
        tk_clr = 1'b1;
      end
    end
    tk_st2 = st1;
    tk_t2  = t1;
    if (st1 == stle_pkg::ST_NEW) begin
      tk_req = 1'b1;
      if (tk_grant) begin
        tk_st2 = stle_pkg::ST_INIT;
        tk_t2  = cfg_r[stle_pkg::REG_HS_TO];
      end else begin
        tk_st2 = stle_pkg::ST_NAUTH;
        tk_t2  = cfg_r[stle_pkg::REG_NAUTH_TO];
      end
    end else if (st1 == stle_pkg::ST_AUTH) begin
      tk_st2 = stle_pkg::ST_MANAGED;
      tk_t2  = cfg_r[stle_pkg::REG_MANAGED_TO];
    end
  end

  // ---------------------------------------------------------------------------
  // shared subtract unit: timer countdown on tick, best-time compare on find
  // ---------------------------------------------------------------------------
  logic [31:0] sub_a, sub_b;
  logic [32:0] sub_d;
  logic        sub_borrow;

  always_comb begin
    if (op_r == stle_pkg::OP_TICK) begin
      sub_a = tk_t2;
      sub_b = cfg_r[stle_pkg::REG_STEP];
    end else begin
      sub_a = best_r;
      sub_b = rd_time;
    end
  end

  assign sub_d      = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_d[32];

  // ---------------------------------------------------------------------------
  // sequencer next state
  // ---------------------------------------------------------------------------
  logic issue;
  logic issue_last;

  assign issue      = (fsm_r == S_SCAN) && iss_r;
  assign issue_last = (op_r == stle_pkg::OP_HS) || (idx_r == LAST_IDX);

  always_comb begin
    fsm_nxt        = fsm_r;
    op_nxt         = op_r;
    peer_nxt       = peer_r;
    hs_ok_nxt      = hs_ok_r;
    start_ok_nxt   = start_ok_r;
    grant_nxt      = grant_r;
    idx_nxt        = idx_r;
    iss_nxt        = iss_r;
    pv_nxt         = 1'b0;
    pidx_nxt       = pidx_r;
    plast_nxt      = 1'b0;
    found_nxt      = found_r;
    fe_nxt         = fe_r;
    best_nxt       = best_r;
    status_nxt     = status_r;
    entry_nxt      = entry_r;
    stop_nxt       = stop_r;
    req_nxt        = req_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_time_nxt   = out_time_r;
    out_stop_nxt   = out_stop_r;
    out_req_nxt    = out_req_r;
    in_ready       = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = idx_r;
    wr_en          = 1'b0;
    wr_addr        = pidx_r;
    wr_state       = rd_st;
    wr_peer        = rd_peer;
    wr_time        = rd_time;

    case (fsm_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt       = in_opcode;
          peer_nxt     = in_peer_id;
          hs_ok_nxt    = in_handshake_ok;
          start_ok_nxt = in_start_ok;
          grant_nxt    = in_start_grant_mask;
          found_nxt    = 1'b0;
          fe_nxt       = '0;
          best_nxt     = 32'd0;
          status_nxt   = stle_pkg::STAT_OK;
          entry_nxt    = 3'd0;
          stop_nxt     = 8'd0;
          req_nxt      = 8'd0;
          idx_nxt      = '0;
          iss_nxt      = 1'b1;
          fsm_nxt      = S_SCAN;
          if (in_opcode == stle_pkg::OP_HS) begin
            idx_nxt = IDX_W'(in_slot);
            // a slot past the table has no entry to look at
            if (32'(in_slot) >= ENTRIES) begin
              status_nxt = stle_pkg::STAT_NOMATCH;
              fsm_nxt    = S_DONE;
            end
          end else if (!(in_opcode == stle_pkg::OP_TICK || in_opcode == stle_pkg::OP_MANAGE ||
                         in_opcode == stle_pkg::OP_OPEN || in_opcode == stle_pkg::OP_FIND)) begin
            fsm_nxt = S_DONE;
          end
        end
      end

      S_SCAN: begin
        // read side: one entry per cycle
        if (issue) begin
          rd_en     = 1'b1;
          idx_nxt   = idx_r + 1'b1;
          pv_nxt    = 1'b1;
          pidx_nxt  = idx_r;
          plast_nxt = issue_last;
          if (issue_last) begin
            iss_nxt = 1'b0;
          end
        end
        // process side: the entry read in the previous cycle
        if (pv_r) begin
          case (op_r)
            stle_pkg::OP_TICK: begin
              wr_en    = 1'b1;
              wr_state = tk_st2;
              wr_peer  = tk_clr ? 32'd0 : rd_peer;
              if (tk_st2 == stle_pkg::ST_EMPTY) begin
                wr_time = tk_t2;
              end else begin
                wr_time = sub_borrow ? 32'd0 : sub_d[31:0];
              end
              if (tk_stop) begin
                stop_nxt = stop_r | pbit;
              end
              if (tk_req) begin
                req_nxt = req_r | pbit;
              end
            end
            stle_pkg::OP_MANAGE, stle_pkg::OP_OPEN: begin
              if (rd_st == stle_pkg::ST_EMPTY && !found_r) begin
                found_nxt = 1'b1;
                fe_nxt    = pidx_r;
              end
            end
            stle_pkg::OP_HS: begin
              if (rd_st == stle_pkg::ST_INIT) begin
                wr_en     = 1'b1;
                stop_nxt  = stop_r | pbit;
                entry_nxt = 3'(pidx_r);
                if (hs_ok_r) begin
                  wr_state = stle_pkg::ST_AUTH;
                  wr_time  = cfg_r[stle_pkg::REG_AUTH_TO];
                end else begin
                  wr_state = stle_pkg::ST_NAUTH;
                  wr_time  = cfg_r[stle_pkg::REG_NAUTH_TO];
                end
              end else begin
                status_nxt = stle_pkg::STAT_NOMATCH;
              end
            end
            stle_pkg::OP_FIND: begin
              // strictly larger time wins, so ties keep the lower index
              if (rd_peer == peer_r && rd_st == stle_pkg::ST_MANAGED && sub_borrow) begin
                found_nxt = 1'b1;
                fe_nxt    = pidx_r;
                best_nxt  = rd_time;
              end
            end
            default: begin
            end
          endcase
          if (plast_r) begin
            fsm_nxt = S_DONE;
            if (op_r == stle_pkg::OP_MANAGE || op_r == stle_pkg::OP_OPEN) begin
              if (found_nxt) begin
                fsm_nxt = S_WRITE;
              end else begin
                status_nxt = stle_pkg::STAT_FULL;
              end
            end else if (op_r == stle_pkg::OP_FIND) begin
              if (found_nxt) begin
                entry_nxt = 3'(fe_nxt);
              end else begin
                status_nxt = stle_pkg::STAT_NOMATCH;
              end
            end
          end
        end
      end

      S_WRITE: begin
        // allocate the first empty entry found by the scan
        wr_en     = 1'b1;
        wr_addr   = fe_r;
        wr_peer   = peer_r;
        entry_nxt = 3'(fe_r);
        if (op_r == stle_pkg::OP_MANAGE) begin
          wr_state = stle_pkg::ST_NEW;
          wr_time  = cfg_r[stle_pkg::REG_NEW_TO];
        end else if (start_ok_r) begin
          wr_state = stle_pkg::ST_INIT;
          wr_time  = cfg_r[stle_pkg::REG_HS_TO];
        end else begin
          wr_state   = stle_pkg::ST_NAUTH;
          wr_time    = cfg_r[stle_pkg::REG_NAUTH_TO];
          status_nxt = stle_pkg::STAT_REFUSED;
        end
        fsm_nxt = S_DONE;
      end

      S_DONE: begin
        // hand the item to the result register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_entry_nxt  = entry_r;
          out_time_nxt   = best_r;
          out_stop_nxt   = stop_r;
          out_req_nxt    = req_r;
          fsm_nxt        = S_IDLE;
        end
      end

      default: begin
        fsm_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      iss_r       <= 1'b0;
      pv_r        <= 1'b0;
      plast_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      iss_r       <= iss_nxt;
      pv_r        <= pv_nxt;
      plast_r     <= plast_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    peer_r       <= peer_nxt;
    hs_ok_r      <= hs_ok_nxt;
    start_ok_r   <= start_ok_nxt;
    grant_r      <= grant_nxt;
    idx_r        <= idx_nxt;
    pidx_r       <= pidx_nxt;
    found_r      <= found_nxt;
    fe_r         <= fe_nxt;
    best_r       <= best_nxt;
    status_r     <= status_nxt;
    entry_r      <= entry_nxt;
    stop_r       <= stop_nxt;
    req_r        <= req_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_time_r   <= out_time_nxt;
    out_stop_r   <= out_stop_nxt;
    out_req_r    <= out_req_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_entry              = out_entry_r;
  assign out_time_left          = out_time_r;
  assign out_stop_mask          = out_stop_r;
  assign out_start_request_mask = out_req_r;

`ifndef SYNTH
  // an accepted item keeps the block busy: input is not taken again in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after accept");

  // table writes only come from the scan or the allocation step
  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (fsm_r == S_SCAN || fsm_r == S_WRITE))
    else $error("table write outside scan or allocation");

  // read data is only consumed in the cycle after a read was issued
  a_read_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> $past(rd_en))
    else $error("entry processed without a read");

  // finishing an item always presents a result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_DONE && (!out_valid_r || out_ready)) |=> out_valid)
    else $error("finished item produced no result");
`endif

endmodule

`default_nettype wire

// ----- dv/session_table_checker.sv -----
// reply checker for the session table engine: mirrors the table and compares every reply
`timescale 1ns / 1ps

module session_table_checker #(
  parameter int ENTRIES = stle_pkg::ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic                         pready,
  input  wire logic [stle_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [stle_pkg::DATA_W-1:0]  pwdata,
  input  wire logic                         in_valid,
  input  wire logic                         in_ready,
  input  wire logic [2:0]                   in_opcode,
  input  wire logic [31:0]                  in_peer_id,
  input  wire logic [2:0]                   in_slot,
  input  wire logic                         in_handshake_ok,
  input  wire logic                         in_start_ok,
  input  wire logic [7:0]                   in_start_grant_mask,
  input  wire logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic [1:0]                   out_status,
  input  wire logic [2:0]                   out_entry,
  input  wire logic [31:0]                  out_time_left,
  input  wire logic [7:0]                   out_stop_mask,
  input  wire logic [7:0]                   out_start_request_mask,
  output int                                mismatch_count,
  output int                                pending_count,
  output int                                compared_count
);
  import stle_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  entry;
    logic [31:0] time_left;
    logic [7:0]  stop_mask;
    logic [7:0]  start_req;
  } session_reply_t;

  logic [3:0]        sess_state [ENTRIES];
  logic [31:0]       sess_peer  [ENTRIES];
  logic [31:0]       sess_time  [ENTRIES];
  logic [DATA_W-1:0] cfg_regs   [NREGS];
  session_reply_t    replies_due [$];
  session_reply_t    got;
  session_reply_t    want;
  int                k;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    compared_count = 0;
  end

  // entering a state loads its timeout; unlisted codes keep the timer
  function automatic void enter_state(input int idx, input logic [3:0] st);
    sess_state[idx] = st;
    case (st)
      ST_NEW:     sess_time[idx] = cfg_regs[REG_NEW_TO];
      ST_INIT:    sess_time[idx] = cfg_regs[REG_HS_TO];
      ST_AUTH:    sess_time[idx] = cfg_regs[REG_AUTH_TO];
      ST_NAUTH:   sess_time[idx] = cfg_regs[REG_NAUTH_TO];
      ST_MANAGED: sess_time[idx] = cfg_regs[REG_MANAGED_TO];
      ST_EXPIRED: sess_time[idx] = cfg_regs[REG_EXPIRED_TO];
      ST_OLD:     sess_time[idx] = cfg_regs[REG_OLD_TO];
      default: ;
    endcase
  endfunction

  function automatic session_reply_t apply_item(
    input logic [2:0] op, input logic [31:0] peer, input logic [2:0] slot,
    input logic hs_ok, input logic start_ok, input logic [7:0] grant);
    session_reply_t r;
    int             i;
    int             hit;
    logic [31:0]    best;
    r    = '0;
    hit  = -1;
    best = '0;
    case (op)
      OP_TICK: begin
        for (i = 0; i < ENTRIES; i++) begin
          // timeout first, then advance, then count down
          if (sess_time[i] == 32'd0) begin
            case (sess_state[i])
              ST_NEW, ST_AUTH, ST_NAUTH, ST_AUTZ, ST_NAUTZ, ST_EXPIRED:
                enter_state(i, ST_OLD);
              ST_INIT: begin
                if (i < 8) r.stop_mask[i] = 1'b1;
                enter_state(i, ST_NAUTH);
              end
              ST_MANAGED: enter_state(i, ST_EXPIRED);
              ST_OLD: begin
                sess_state[i] = ST_EMPTY;
                sess_peer[i]  = '0;
                sess_time[i]  = '0;
              end
              default: ;
            endcase
          end
          if (sess_state[i] == ST_NEW) begin
            if (i < 8) r.start_req[i] = 1'b1;
            if (i < 8 && grant[i[2:0]]) enter_state(i, ST_INIT);
            else enter_state(i, ST_NAUTH);
          end else if (sess_state[i] == ST_AUTH) begin
            enter_state(i, ST_MANAGED);
          end
          if (sess_state[i] != ST_EMPTY) begin
            if (sess_time[i] >= cfg_regs[REG_STEP]) sess_time[i] = sess_time[i] - cfg_regs[REG_STEP];
            else sess_time[i] = 32'd0;
          end
        end
      end
      OP_MANAGE, OP_OPEN: begin
        for (i = 0; i < ENTRIES; i++)
          if (hit < 0 && sess_state[i] == ST_EMPTY) hit = i;
        if (hit < 0) begin
          r.status = STAT_FULL;
        end else begin
          sess_peer[hit] = peer;
          r.entry = hit[2:0];
          if (op == OP_MANAGE) begin
            sess_time[hit] = '0;
            enter_state(hit, ST_NEW);
          end else begin
            enter_state(hit, ST_INIT);
            if (!start_ok) begin
              enter_state(hit, ST_NAUTH);
              r.status = STAT_REFUSED;
            end
          end
        end
      end
      OP_HS: begin
        if (int'(slot) < ENTRIES && sess_state[slot] == ST_INIT) begin
          enter_state(int'(slot), hs_ok ? ST_AUTH : ST_NAUTH);
          r.stop_mask[slot] = 1'b1;
          r.entry = slot;
        end else begin
          r.status = STAT_NOMATCH;
        end
      end
      OP_FIND: begin
        // strictly larger wins, so ties keep the lowest index
        for (i = 0; i < ENTRIES; i++) begin
          if (sess_peer[i] == peer && sess_state[i] == ST_MANAGED && sess_time[i] > best) begin
            hit  = i;
            best = sess_time[i];
          end
        end
        if (hit < 0) begin
          r.status = STAT_NOMATCH;
        end else begin
          r.entry     = hit[2:0];
          r.time_left = best;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: reply %0d %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, compared_count, what, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (k = 0; k < ENTRIES; k++) begin
        sess_state[k] = ST_EMPTY;
        sess_peer[k]  = '0;
        sess_time[k]  = '0;
      end
      for (k = 0; k < NREGS; k++) cfg_regs[k] = CFG_RESET[k];
    end else begin
      if (psel && penable && pwrite && pready) cfg_regs[paddr[ADDR_W-1:2]] = pwdata;
      // replies are retired before the new item is predicted
      if (out_valid && out_ready) begin
        got.status    = out_status;
        got.entry     = out_entry;
        got.time_left = out_time_left;
        got.stop_mask = out_stop_mask;
        got.start_req = out_start_request_mask;
        if (replies_due.size() == 0) begin
          $display("%0t: reply with nothing expected, expected none, actual 0x%0h",
                   $time, got);
          mismatch_count++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("entry", 32'(want.entry), 32'(got.entry));
          check_field("time_left", want.time_left, got.time_left);
          check_field("stop_mask", 32'(want.stop_mask), 32'(got.stop_mask));
          check_field("start_request_mask", 32'(want.start_req), 32'(got.start_req));
          compared_count++;
        end
      end
      if (in_valid && in_ready)
        replies_due.push_back(apply_item(in_opcode, in_peer_id, in_slot, in_handshake_ok,
                                         in_start_ok, in_start_grant_mask));
    end
    pending_count = replies_due.size();
  end

endmodule

// ----- dv/session_table_lifecycle_engine_core_test.sv -----
// testbench top: clock, reset, register programming, item stimulus and verdict
`timescale 1ns / 1ps

module session_table_lifecycle_engine_core_test;
  import stle_pkg::*;

  // no handshake of any kind for this long means the block is hung
  localparam int WATCHDOG_LIMIT = 3000;
  // counted items per random phase, six phases
  localparam int PHASE_ITEMS    = 140;
  // settle time after the drain, with slack for the tail
  localparam int SETTLE_CYCLES  = ENTRIES_DEF + 8;

  // opcodes the block does not decode
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic              in_valid            = 1'b0;
  logic              in_ready;
  logic [2:0]        in_opcode           = '0;
  logic [31:0]       in_peer_id          = '0;
  logic [2:0]        in_slot             = '0;
  logic              in_handshake_ok     = 1'b0;
  logic              in_start_ok         = 1'b0;
  logic [7:0]        in_start_grant_mask = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [2:0]        out_entry;
  logic [31:0]       out_time_left;
  logic [7:0]        out_stop_mask;
  logic [7:0]        out_start_request_mask;

  int mismatch_count;
  int pending_count;
  int compared_count;

  // stall odds in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int phase_items   = 0;
  int idle_cycles   = 0;
  int phase;

  // last reply seen, used to steer a session to the entry it got
  logic [2:0] last_entry  = '0;
  logic [1:0] last_status = '0;

  always #10 clk = ~clk;

  session_table_lifecycle_engine_core #(
    .ENTRIES(ENTRIES_DEF)
  ) i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_opcode              (in_opcode),
    .in_peer_id             (in_peer_id),
    .in_slot                (in_slot),
    .in_handshake_ok        (in_handshake_ok),
    .in_start_ok            (in_start_ok),
    .in_start_grant_mask    (in_start_grant_mask),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_entry              (out_entry),
    .out_time_left          (out_time_left),
    .out_stop_mask          (out_stop_mask),
    .out_start_request_mask (out_start_request_mask)
  );

  session_table_checker #(
    .ENTRIES(ENTRIES_DEF)
  ) i_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .pready                 (pready),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_opcode              (in_opcode),
    .in_peer_id             (in_peer_id),
    .in_slot                (in_slot),
    .in_handshake_ok        (in_handshake_ok),
    .in_start_ok            (in_start_ok),
    .in_start_grant_mask    (in_start_grant_mask),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_entry              (out_entry),
    .out_time_left          (out_time_left),
    .out_stop_mask          (out_stop_mask),
    .out_start_request_mask (out_start_request_mask),
    .mismatch_count         (mismatch_count),
    .pending_count          (pending_count),
    .compared_count         (compared_count)
  );

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      last_entry  <= out_entry;
      last_status <= out_status;
    end
  end

  // watchdog: any handshake or register access counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d replies outstanding",
               $time, idle_cycles, pending_count);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one item: optional sender gap, then hold valid until accepted
  task automatic drive_item(input logic [2:0] op, input logic [31:0] peer,
                            input logic [2:0] slot, input logic hs_ok,
                            input logic start_ok, input logic [7:0] grant);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid            = 1'b1;
    in_opcode           = op;
    in_peer_id          = peer;
    in_slot             = slot;
    in_handshake_ok     = hs_ok;
    in_start_ok         = start_ok;
    in_start_grant_mask = grant;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    // spare opcodes get a plain reply from the block and do not count toward a phase
    if (op <= OP_FIND) phase_items++;
  endtask

  // drop valid and wait for every outstanding reply
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // apb write: setup cycle, access cycle, done when pready is seen
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic load_settings(input logic [31:0] step, input logic [31:0] t_new,
                               input logic [31:0] t_hs, input logic [31:0] t_auth,
                               input logic [31:0] t_nauth, input logic [31:0] t_managed,
                               input logic [31:0] t_expired, input logic [31:0] t_old);
    write_register(REG_STEP, step);
    write_register(REG_NEW_TO, t_new);
    write_register(REG_HS_TO, t_hs);
    write_register(REG_AUTH_TO, t_auth);
    write_register(REG_NAUTH_TO, t_nauth);
    write_register(REG_MANAGED_TO, t_managed);
    write_register(REG_EXPIRED_TO, t_expired);
    write_register(REG_OLD_TO, t_old);
  endtask

  // small peer pool so finds hit and ties appear, with a random one now and then
  function automatic logic [31:0] pick_peer();
    case ($urandom_range(4))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h0000_0000;
      2:       return 32'h1234_5678;
      3:       return 32'h8000_0001;
      default: return $urandom;
    endcase
  endfunction

  // short directed walk at reset settings: empty table, spare opcodes,
  // every allocation outcome, handshake pass and fail, a find tie, full table
  task automatic run_directed();
    drive_item(OP_FIND, 32'h0000_0000, 3'd0, 1'b0, 1'b0, 8'h00);
    drive_item(OP_HS, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1, 8'hFF);
    drive_item(OP_SPARE_A, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1, 8'hFF);
    drive_item(OP_SPARE_B, 32'h0000_0000, 3'd0, 1'b0, 1'b0, 8'h00);
    drive_item(OP_SPARE_C, $urandom, 3'd5, 1'b1, 1'b0, 8'hA5);
    drive_item(OP_MANAGE, 32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 8'h00);
    drive_item(OP_OPEN, 32'hFFFF_FFFF, 3'd7, 1'b0, 1'b1, 8'hFF);
    // start refused goes straight to nauth
    drive_item(OP_OPEN, 32'h0000_0000, 3'd0, 1'b1, 1'b0, 8'h00);
    drive_item(OP_MANAGE, 32'h0000_0001, 3'd3, 1'b1, 1'b1, 8'h5A);
    drive_item(OP_OPEN, 32'h8000_0001, 3'd2, 1'b0, 1'b1, 8'hFF);
    // entry 0 granted, entry 3 not
    drive_item(OP_TICK, $urandom, 3'd0, 1'b0, 1'b0, 8'h01);
    drive_item(OP_HS, 32'h0000_0000, 3'd0, 1'b1, 1'b0, 8'h00);
    drive_item(OP_HS, 32'h0000_0000, 3'd1, 1'b1, 1'b0, 8'h00);
    drive_item(OP_HS, 32'h0000_0000, 3'd4, 1'b0, 1'b1, 8'h00);
    // handshake result for an entry that is not waiting on one
    drive_item(OP_HS, 32'h0000_0000, 3'd2, 1'b0, 1'b1, 8'h00);
    // both auth entries become managed with equal time: lowest index wins
    drive_item(OP_TICK, $urandom, 3'd7, 1'b1, 1'b1, 8'hFE);
    drive_item(OP_FIND, 32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 8'h00);
    drive_item(OP_FIND, 32'h0000_0000, 3'd0, 1'b0, 1'b0, 8'h00);
    repeat (3) drive_item(OP_MANAGE, $urandom, 3'd0, 1'b0, 1'b0, 8'h00);
    drive_item(OP_MANAGE, 32'h1234_5678, 3'd0, 1'b0, 1'b0, 8'h00);
    drive_item(OP_OPEN, 32'h1234_5678, 3'd0, 1'b0, 1'b1, 8'h00);
  endtask

  // one session lifecycle: allocate, grant, handshake, promote, look it up
  task automatic run_session();
    logic [31:0] peer;
    logic [2:0]  slot_got;
    logic [7:0]  grant;
    logic        via_open;
    peer     = pick_peer();
    via_open = 1'($urandom_range(1));
    if (via_open)
      drive_item(OP_OPEN, peer, 3'($urandom_range(7)), 1'($urandom_range(1)),
                 ($urandom_range(9) != 0), 8'($urandom_range(255)));
    else
      drive_item(OP_MANAGE, peer, 3'($urandom_range(7)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 8'($urandom_range(255)));
    wait_drained();
    slot_got = last_entry;
    if (last_status == STAT_FULL) begin
      // table full: let time run so entries age out
      drive_item(OP_TICK, pick_peer(), 3'($urandom_range(7)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 8'($urandom_range(255)));
    end else begin
      if (!via_open) begin
        grant = 8'($urandom_range(255));
        if ($urandom_range(4) != 0) grant[slot_got] = 1'b1;
        drive_item(OP_TICK, pick_peer(), 3'($urandom_range(7)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), grant);
      end
      if ($urandom_range(3) == 0)
        drive_item(3'($urandom_range(4)), pick_peer(), 3'($urandom_range(7)),
                   1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)));
      drive_item(OP_HS, $urandom, slot_got, ($urandom_range(3) != 0), 1'($urandom_range(1)),
                 8'($urandom_range(255)));
      drive_item(OP_TICK, $urandom, 3'($urandom_range(7)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 8'($urandom_range(255)));
      repeat ($urandom_range(3, 1)) begin
        drive_item(OP_FIND, peer, 3'($urandom_range(7)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 8'($urandom_range(255)));
        if ($urandom_range(1))
          drive_item(OP_TICK, $urandom, 3'($urandom_range(7)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
  endtask

  // unrelated traffic, spare opcodes included
  task automatic send_noise();
    repeat ($urandom_range(3, 1))
      drive_item(3'($urandom_range(7)), $urandom_range(1) ? pick_peer() : $urandom,
                 3'($urandom_range(7)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 8'($urandom_range(255)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    // phase 0 keeps reset settings; phase 1 freezes timers at their top value,
    // phase 2 drains everything with zero timeouts and a full-range step,
    // later phases use short random lifetimes
    for (phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        1: load_settings(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: load_settings(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        3, 4, 5: load_settings($urandom_range(500, 1), $urandom_range(3000),
                               $urandom_range(3000), $urandom_range(3000),
                               $urandom_range(3000), $urandom_range(3000),
                               $urandom_range(3000), $urandom_range(3000));
        default: ;
      endcase
      // stall pattern: sender light / receiver heavy, then swapped, then none
      send_idle_pct = (phase < 2) ? 32 : (phase < 4) ? 82 : 0;
      recv_idle_pct = (phase < 2) ? 82 : (phase < 4) ? 32 : 0;
      phase_items   = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(3) != 0) run_session();
        else send_noise();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items and %0d compared replies over reset, frozen, draining",
             items_sent, compared_count);
    $display("and three random timer settings, with stalls on either side and none");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d replies never arrived", mismatch_count, pending_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
